// ===== sv/scq_pkg.sv =====
// Shared types for the segment-to-quadrilateral clipper.
// No dependencies; used by scq_hit, scq_solve, scq_div and the top level.
package scq_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_CLIP     = 2'd0,
    STAT_PARALLEL = 2'd1,
    STAT_MISS     = 2'd2
  } scq_status_t;

  // Control word that travels beside the data in every pipeline stage.
  typedef struct packed {
    logic        valid;
    scq_status_t status;
  } scq_ctl_t;

endpackage

// ===== sv/scq_in_if.sv =====
// Input channel of the clipper: valid/ready plus segment and corner coordinates.
// Standalone; no package dependency.
interface scq_in_if #(parameter int W = 14);
  logic         valid;
  logic         ready;
  logic [W-1:0] seg_start_x;
  logic [W-1:0] seg_start_y;
  logic [W-1:0] seg_end_x;
  logic [W-1:0] seg_end_y;
  logic [W-1:0] corner0_x;
  logic [W-1:0] corner0_y;
  logic [W-1:0] corner1_x;
  logic [W-1:0] corner1_y;
  logic [W-1:0] corner2_x;
  logic [W-1:0] corner2_y;
  logic [W-1:0] corner3_x;
  logic [W-1:0] corner3_y;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           corner0_x, corner0_y, corner1_x, corner1_y,
           corner2_x, corner2_y, corner3_x, corner3_y,
    input  ready
  );
  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           corner0_x, corner0_y, corner1_x, corner1_y,
           corner2_x, corner2_y, corner3_x, corner3_y,
    output ready
  );
endinterface

// ===== sv/scq_out_if.sv =====
// Result channel of the clipper: valid/ready plus clipped segment and status.
// Standalone; no package dependency.
interface scq_out_if #(parameter int W = 14);
  logic         valid;
  logic         ready;
  logic [W-1:0] clip_x;
  logic [W-1:0] clip_y;
  logic [W-1:0] kept_x;
  logic [W-1:0] kept_y;
  logic [1:0]   status;

  modport source (
    output valid, clip_x, clip_y, kept_x, kept_y, status,
    input  ready
  );
  modport sink (
    input  valid, clip_x, clip_y, kept_x, kept_y, status,
    output ready
  );
endinterface

// ===== sv/scq_hit.sv =====
// Edge hit detection: orientation products, segment tests and first-hit select.
// Two register stages. Depends on scq_pkg.
module scq_hit #(
  parameter int W = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [W-1:0]          sx,
  input  logic [W-1:0]          sy,
  input  logic [W-1:0]          ex,
  input  logic [W-1:0]          ey,
  input  logic [3:0][W-1:0]     cx,
  input  logic [3:0][W-1:0]     cy,
  output scq_pkg::scq_ctl_t     ctl_o,
  output logic [W-1:0]          sx_o,
  output logic [W-1:0]          sy_o,
  output logic [W-1:0]          ex_o,
  output logic [W-1:0]          ey_o,
  output logic [W-1:0]          e0x_o,
  output logic [W-1:0]          e0y_o,
  output logic [W-1:0]          e1x_o,
  output logic [W-1:0]          e1y_o
);

  localparam int PW = 2 * W + 2;

  typedef enum logic [1:0] {TURN_ZERO, TURN_POS, TURN_NEG} turn_t;

  function automatic logic signed [W:0] dif(input logic [W-1:0] a, input logic [W-1:0] b);
    dif = $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  function automatic turn_t turn_of(input logic signed [PW-1:0] p, input logic signed [PW-1:0] q);
    logic signed [PW:0] v;
    v = {p[PW-1], p} - {q[PW-1], q};
    if (v == '0) turn_of = TURN_ZERO;
    else if (!v[PW]) turn_of = TURN_POS;
    else turn_of = TURN_NEG;
  endfunction

  // True when point b lies in the box spanned by a and c.
  function automatic logic in_box(input logic [W-1:0] ax, input logic [W-1:0] ay,
                                  input logic [W-1:0] bx, input logic [W-1:0] by,
                                  input logic [W-1:0] cx_, input logic [W-1:0] cy_);
    logic [W-1:0] lox, hix, loy, hiy;
    lox = (ax < cx_) ? ax : cx_;
    hix = (ax < cx_) ? cx_ : ax;
    loy = (ay < cy_) ? ay : cy_;
    hiy = (ay < cy_) ? cy_ : ay;
    in_box = (bx >= lox) && (bx <= hix) && (by >= loy) && (by <= hiy);
  endfunction

  // Stage 1: the eight orientation products of each edge.
  logic signed [PW-1:0] prod_r [4][8];
  logic                 v1_r;
  logic [W-1:0]         sx_r, sy_r, ex_r, ey_r;
  logic [3:0][W-1:0]    cx_r, cy_r;

  for (genvar i = 0; i < 4; i++) begin : g_prod
    localparam int J = (i + 1) % 4;
    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[i][0] <= dif(ey, sy) * dif(cx[i], ex);
        prod_r[i][1] <= dif(ex, sx) * dif(cy[i], ey);
        prod_r[i][2] <= dif(ey, sy) * dif(cx[J], ex);
        prod_r[i][3] <= dif(ex, sx) * dif(cy[J], ey);
        prod_r[i][4] <= dif(cy[J], cy[i]) * dif(sx, cx[J]);
        prod_r[i][5] <= dif(cx[J], cx[i]) * dif(sy, cy[J]);
        prod_r[i][6] <= dif(cy[J], cy[i]) * dif(ex, cx[J]);
        prod_r[i][7] <= dif(cx[J], cx[i]) * dif(ey, cy[J]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= sx;
      sy_r <= sy;
      ex_r <= ex;
      ey_r <= ey;
      cx_r <= cx;
      cy_r <= cy;
    end
  end

  // Stage 2: segment tests per edge, then the first edge that is hit.
  logic [3:0] meet;

  for (genvar i = 0; i < 4; i++) begin : g_meet
    localparam int J = (i + 1) % 4;
    turn_t t1, t2, t3, t4;
    always_comb begin
      t1 = turn_of(prod_r[i][0], prod_r[i][1]);
      t2 = turn_of(prod_r[i][2], prod_r[i][3]);
      t3 = turn_of(prod_r[i][4], prod_r[i][5]);
      t4 = turn_of(prod_r[i][6], prod_r[i][7]);
      meet[i] = ((t1 != t2) && (t3 != t4)) ||
                ((t1 == TURN_ZERO) && in_box(sx_r, sy_r, cx_r[i], cy_r[i], ex_r, ey_r)) ||
                ((t2 == TURN_ZERO) && in_box(sx_r, sy_r, cx_r[J], cy_r[J], ex_r, ey_r)) ||
                ((t3 == TURN_ZERO) && in_box(cx_r[i], cy_r[i], sx_r, sy_r, cx_r[J], cy_r[J])) ||
                ((t4 == TURN_ZERO) && in_box(cx_r[i], cy_r[i], ex_r, ey_r, cx_r[J], cy_r[J]));
    end
  end

  logic [1:0] sel;
  logic [1:0] sel_next;

  always_comb begin
    sel = 2'd0;
    for (int k = 3; k >= 0; k--) begin
      if (meet[k]) sel = 2'(k);
    end
    sel_next = sel + 2'd1;
  end

  scq_pkg::scq_ctl_t ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '{valid: 1'b0, status: scq_pkg::STAT_MISS};
    end else if (en) begin
      ctl_r.valid  <= v1_r;
      ctl_r.status <= (|meet) ? scq_pkg::STAT_CLIP : scq_pkg::STAT_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_o  <= sx_r;
      sy_o  <= sy_r;
      ex_o  <= ex_r;
      ey_o  <= ey_r;
      e0x_o <= cx_r[sel];
      e0y_o <= cy_r[sel];
      e1x_o <= cx_r[sel_next];
      e1y_o <= cy_r[sel_next];
    end
  end

  assign ctl_o = ctl_r;

endmodule

// ===== sv/scq_solve.sv =====
// Line intersection by Cramer's rule: line coefficients, determinant, numerators.
// Four register stages. Depends on scq_pkg.
module scq_solve #(
  parameter int W = 14,
  localparam int NW = 3 * W + 5,
  localparam int DW = 2 * W + 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  scq_pkg::scq_ctl_t ctl_i,
  input  logic [W-1:0]      sx,
  input  logic [W-1:0]      sy,
  input  logic [W-1:0]      ex,
  input  logic [W-1:0]      ey,
  input  logic [W-1:0]      e0x,
  input  logic [W-1:0]      e0y,
  input  logic [W-1:0]      e1x,
  input  logic [W-1:0]      e1y,
  output scq_pkg::scq_ctl_t ctl_o,
  output logic [1:0][NW-1:0] num_o,
  output logic [1:0]        neg_o,
  output logic [DW-1:0]     den_o,
  output logic [3:0][W-1:0] pt_o
);

  localparam int PW = 2 * W + 2;
  localparam int MW = 3 * W + 4;

  function automatic logic signed [W:0] dif(input logic [W-1:0] a, input logic [W-1:0] b);
    dif = $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  function automatic logic signed [W:0] sx1(input logic [W-1:0] a);
    sx1 = $signed({1'b0, a});
  endfunction

  scq_pkg::scq_ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r;

  // Stage 1: coefficients and the products that form c1, c2 and the determinant.
  logic signed [W:0]    a1_r, b1_r, a2_r, b2_r;
  logic signed [PW-1:0] m1_r, m2_r, m3_r, m4_r, m5_r, m6_r;
  logic [3:0][W-1:0]    pt1_r, pt2_r, pt3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= dif(ey, sy);
      b1_r  <= dif(sx, ex);
      a2_r  <= dif(e1y, e0y);
      b2_r  <= dif(e0x, e1x);
      m1_r  <= dif(ey, sy) * sx1(sx);
      m2_r  <= dif(sx, ex) * sx1(sy);
      m3_r  <= dif(e1y, e0y) * sx1(e0x);
      m4_r  <= dif(e0x, e1x) * sx1(e0y);
      m5_r  <= dif(ey, sy) * dif(e0x, e1x);
      m6_r  <= dif(e1y, e0y) * dif(sx, ex);
      pt1_r <= {ey, ex, sy, sx};
    end
  end

  // Stage 2: c1, c2 and the determinant.
  logic signed [W:0]    a1_2r, b1_2r, a2_2r, b2_2r;
  logic signed [DW-1:0] c1_r, c2_r, det_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a1_2r <= a1_r;
      b1_2r <= b1_r;
      a2_2r <= a2_r;
      b2_2r <= b2_r;
      c1_r  <= DW'(m1_r) + DW'(m2_r);
      c2_r  <= DW'(m3_r) + DW'(m4_r);
      det_r <= DW'(m5_r) - DW'(m6_r);
      pt2_r <= pt1_r;
    end
  end

  // Stage 3: numerator products.
  logic signed [MW-1:0] n1_r, n2_r, n3_r, n4_r;
  logic signed [DW-1:0] det3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r   <= b2_2r * c1_r;
      n2_r   <= b1_2r * c2_r;
      n3_r   <= a1_2r * c2_r;
      n4_r   <= a2_2r * c1_r;
      det3_r <= det_r;
      pt3_r  <= pt2_r;
    end
  end

  // Stage 4: numerators, magnitudes and quotient signs.
  logic signed [NW-1:0] nx, ny;
  logic [NW-1:0]        ax, ay;
  logic [DW-1:0]        ad;

  always_comb begin
    nx = NW'(n1_r) - NW'(n2_r);
    ny = NW'(n3_r) - NW'(n4_r);
    ax = nx[NW-1] ? NW'(-nx) : NW'(nx);
    ay = ny[NW-1] ? NW'(-ny) : NW'(ny);
    ad = det3_r[DW-1] ? DW'(-det3_r) : DW'(det3_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_o[0] <= ax;
      num_o[1] <= ay;
      neg_o[0] <= nx[NW-1] ^ det3_r[DW-1];
      neg_o[1] <= ny[NW-1] ^ det3_r[DW-1];
      den_o    <= ad;
      pt_o     <= pt3_r;
    end
  end

  // Control travels with the data; a hit with a zero determinant is parallel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '{valid: 1'b0, status: scq_pkg::STAT_MISS};
      ctl2_r <= '{valid: 1'b0, status: scq_pkg::STAT_MISS};
      ctl3_r <= '{valid: 1'b0, status: scq_pkg::STAT_MISS};
      ctl4_r <= '{valid: 1'b0, status: scq_pkg::STAT_MISS};
    end else if (en) begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r.valid <= ctl3_r.valid;
      if (ctl3_r.status == scq_pkg::STAT_CLIP && det3_r == '0) begin
        ctl4_r.status <= scq_pkg::STAT_PARALLEL;
      end else begin
        ctl4_r.status <= ctl3_r.status;
      end
    end
  end

  assign ctl_o = ctl4_r;

endmodule

// ===== sv/scq_div.sv =====
// Pipelined restoring divider for the two intersection coordinates.
// One overflow stage plus one stage per quotient bit. Depends on scq_pkg.
module scq_div #(
  parameter int W = 14,
  localparam int NW = 3 * W + 5,
  localparam int DW = 2 * W + 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  scq_pkg::scq_ctl_t  ctl_i,
  input  logic [1:0][NW-1:0] num_i,
  input  logic [1:0]         neg_i,
  input  logic [DW-1:0]      den_i,
  input  logic [3:0][W-1:0]  pt_i,
  output scq_pkg::scq_ctl_t  ctl_o,
  output logic [1:0][W-1:0]  quo_o,
  output logic [1:0]         ovf_o,
  output logic [1:0]         neg_o,
  output logic [3:0][W-1:0]  pt_o
);

  scq_pkg::scq_ctl_t  ctl_r [W+1];
  logic [1:0][NW-1:0] rem_r [W+1];
  logic [1:0][W-1:0]  quo_r [W+1];
  logic [1:0]         ovf_r [W+1];
  logic [1:0]         neg_r [W+1];
  logic [DW-1:0]      den_r [W+1];
  logic [3:0][W-1:0]  pt_r  [W+1];

  for (genvar s = 0; s <= W; s++) begin : g_stg
    logic [1:0][NW-1:0] rem_nxt;
    logic [1:0][W-1:0]  quo_nxt;
    logic [1:0]         ovf_nxt;

    if (s == 0) begin : g_first
      // A quotient that does not fit in W bits is flagged as overflow.
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          ovf_nxt[l] = num_i[l] >= (NW'(den_i) << W);
          rem_nxt[l] = num_i[l];
          quo_nxt[l] = '0;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ctl_r[s] <= '{valid: 1'b0, status: scq_pkg::STAT_MISS};
        end else if (en) begin
          ctl_r[s] <= ctl_i;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt;
          quo_r[s] <= quo_nxt;
          ovf_r[s] <= ovf_nxt;
          neg_r[s] <= neg_i;
          den_r[s] <= den_i;
          pt_r[s]  <= pt_i;
        end
      end
    end else begin : g_bit
      // Quotient bit W-s: subtract the shifted divisor when it fits.
      logic [NW-1:0] trial;
      always_comb begin
        trial = NW'(den_r[s-1]) << (W - s);
        for (int l = 0; l < 2; l++) begin
          quo_nxt[l] = quo_r[s-1][l];
          ovf_nxt[l] = ovf_r[s-1][l];
          if (rem_r[s-1][l] >= trial) begin
            rem_nxt[l] = rem_r[s-1][l] - trial;
            quo_nxt[l][W-s] = 1'b1;
          end else begin
            rem_nxt[l] = rem_r[s-1][l];
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ctl_r[s] <= '{valid: 1'b0, status: scq_pkg::STAT_MISS};
        end else if (en) begin
          ctl_r[s] <= ctl_r[s-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt;
          quo_r[s] <= quo_nxt;
          ovf_r[s] <= ovf_nxt;
          neg_r[s] <= neg_r[s-1];
          den_r[s] <= den_r[s-1];
          pt_r[s]  <= pt_r[s-1];
        end
      end
    end
  end

  assign ctl_o = ctl_r[W];
  assign quo_o = quo_r[W];
  assign ovf_o = ovf_r[W];
  assign neg_o = neg_r[W];
  assign pt_o  = pt_r[W];

endmodule

// ===== sv/segment_clip_to_quad_top.sv =====
// Top level of the segment-to-quadrilateral clipper: hit test, solver, divider.
// Depends on scq_pkg, scq_in_if, scq_out_if, scq_hit, scq_solve and scq_div.
//
//   channel   direction  handshake      payload
//   in_ch     sink       valid/ready    segment start/end, four corners
//   out_ch    source     valid/ready    clip point, kept point, status
//
// Items pass through two hit-test stages, four solver stages,
// COORD_BITS + 1 divider stages and one output register.
// One item is taken every cycle while the result side keeps taking items.
// A stall freezes every stage at once; in_ch.ready is low only while the
// output register holds an item that has not been taken.
// Synchronous reset clears the valid bits of all stages.
module segment_clip_to_quad_top #(
  parameter int COORD_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  scq_in_if.sink      in_ch,
  scq_out_if.source   out_ch
);

  localparam int W  = COORD_BITS;
  localparam int NW = 3 * W + 5;
  localparam int DW = 2 * W + 3;

  logic en;
  logic out_valid_r;

  // The whole pipeline advances when the output register is free or emptied.
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Edge hit detection.
  scq_pkg::scq_ctl_t hit_ctl;
  logic [W-1:0]      h_sx, h_sy, h_ex, h_ey, h_e0x, h_e0y, h_e1x, h_e1y;

  scq_hit #(.W(W)) u_hit (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .sx       (in_ch.seg_start_x),
    .sy       (in_ch.seg_start_y),
    .ex       (in_ch.seg_end_x),
    .ey       (in_ch.seg_end_y),
    .cx       ({in_ch.corner3_x, in_ch.corner2_x, in_ch.corner1_x, in_ch.corner0_x}),
    .cy       ({in_ch.corner3_y, in_ch.corner2_y, in_ch.corner1_y, in_ch.corner0_y}),
    .ctl_o    (hit_ctl),
    .sx_o     (h_sx),
    .sy_o     (h_sy),
    .ex_o     (h_ex),
    .ey_o     (h_ey),
    .e0x_o    (h_e0x),
    .e0y_o    (h_e0y),
    .e1x_o    (h_e1x),
    .e1y_o    (h_e1y)
  );

  // Cramer's rule numerators and determinant.
  scq_pkg::scq_ctl_t  sol_ctl;
  logic [1:0][NW-1:0] sol_num;
  logic [1:0]         sol_neg;
  logic [DW-1:0]      sol_den;
  logic [3:0][W-1:0]  sol_pt;

  scq_solve #(.W(W)) u_solve (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (hit_ctl),
    .sx    (h_sx),
    .sy    (h_sy),
    .ex    (h_ex),
    .ey    (h_ey),
    .e0x   (h_e0x),
    .e0y   (h_e0y),
    .e1x   (h_e1x),
    .e1y   (h_e1y),
    .ctl_o (sol_ctl),
    .num_o (sol_num),
    .neg_o (sol_neg),
    .den_o (sol_den),
    .pt_o  (sol_pt)
  );

  // Division of both coordinates.
  scq_pkg::scq_ctl_t div_ctl;
  logic [1:0][W-1:0] div_quo;
  logic [1:0]        div_ovf;
  logic [1:0]        div_neg;
  logic [3:0][W-1:0] div_pt;

  scq_div #(.W(W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (sol_ctl),
    .num_i (sol_num),
    .neg_i (sol_neg),
    .den_i (sol_den),
    .pt_i  (sol_pt),
    .ctl_o (div_ctl),
    .quo_o (div_quo),
    .ovf_o (div_ovf),
    .neg_o (div_neg),
    .pt_o  (div_pt)
  );

  // Clamp the quotients and pick the result points by status.
  logic [1:0][W-1:0] clip_nxt;
  logic [1:0][W-1:0] kept_nxt;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (div_ctl.status == scq_pkg::STAT_CLIP) begin
        if (div_neg[l]) begin
          clip_nxt[l] = '0;
        end else if (div_ovf[l]) begin
          clip_nxt[l] = '1;
        end else begin
          clip_nxt[l] = div_quo[l];
        end
        kept_nxt[l] = div_pt[l];
      end else begin
        clip_nxt[l] = div_pt[l];
        kept_nxt[l] = div_pt[l+2];
      end
    end
  end

  // Output register.
  logic [1:0][W-1:0]     clip_r;
  logic [1:0][W-1:0]     kept_r;
  scq_pkg::scq_status_t  status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clip_r   <= clip_nxt;
      kept_r   <= kept_nxt;
      status_r <= div_ctl.status;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.clip_x = clip_r[0];
  assign out_ch.clip_y = clip_r[1];
  assign out_ch.kept_x = kept_r[0];
  assign out_ch.kept_y = kept_r[1];
  assign out_ch.status = status_r;

endmodule
